// ----- hdl/chkd_pkg.sv -----
package chkd_pkg;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       has_byte;
      logic       final_res;
      logic [1:0] status;
   } rsp_type;

   // Size line report from the parser to the framing control.
   typedef struct packed {
      logic line_end;   // this byte is the LF of a CR LF pair
      logic line_full;  // this byte is the last one the line may hold
      logic size_zero;  // the parsed chunk size is zero
   } line_stat_type;

   // Framing phases.
   localparam logic [1:0] PH_SIZE = 2'd0;
   localparam logic [1:0] PH_DATA = 2'd1;
   localparam logic [1:0] PH_SKIP = 2'd2;
   localparam logic [1:0] PH_DONE = 2'd3;

   // Size parser phases.
   localparam logic [2:0] HX_BLANK  = 3'd0;
   localparam logic [2:0] HX_SIGN   = 3'd1;
   localparam logic [2:0] HX_ZERO   = 3'd2;
   localparam logic [2:0] HX_DIGITS = 3'd3;
   localparam logic [2:0] HX_STOP   = 3'd4;

   // Final status codes.
   localparam logic [1:0] ST_ZERO_CHUNK = 2'd0;
   localparam logic [1:0] ST_IN_DATA    = 2'd1;
   localparam logic [1:0] ST_MALFORMED  = 2'd2;

   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_LOW_X = 8'h78;
   localparam logic [7:0] CH_UP_X  = 8'h58;

   // Bit 4 flags a hex digit, bits 3:0 carry its value.
   function automatic logic [4:0] hex_digit(input logic [7:0] b);
      logic [4:0] r;
      r = 5'd0;
      if (b inside {[8'h30:8'h39]}) begin
         r = {1'b1, 4'(b - 8'h30)};
      end else if (b inside {[8'h61:8'h66]}) begin
         r = {1'b1, 4'(b - 8'h57)};
      end else if (b inside {[8'h41:8'h46]}) begin
         r = {1'b1, 4'(b - 8'h37)};
      end
      return r;
   endfunction

endpackage

// ----- hdl/chkd_line_parser.sv -----
module chkd_line_parser #(
   parameter int LINE_MAX  = 16,
   parameter int SIZE_BITS = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [7:0]             in_byte,
   input  logic                   step,
   input  logic                   restart,
   output chkd_pkg::line_stat_type stat,
   output logic [SIZE_BITS-1:0]   size_value
);

   localparam int LC_W = $clog2(LINE_MAX);

   logic [2:0]           hex_ff, hex_in, hex_cur;
   logic [SIZE_BITS-1:0] size_ff, size_in, acc;
   logic                 prev_cr_ff, prev_cr_in;
   logic [LC_W-1:0]      count_ff, count_in;
   logic [4:0]           digit;
   logic                 is_digit;

   always_comb begin
      digit    = chkd_pkg::hex_digit(in_byte);
      is_digit = digit[4];
      // Saturate once another digit would carry out of the top nibble.
      if (|size_ff[SIZE_BITS-1 -: 4]) begin
         acc = '1;
      end else begin
         acc = {size_ff[SIZE_BITS-5:0], digit[3:0]};
      end
      // A CR not followed by LF closes the digit field.
      hex_cur = prev_cr_ff ? chkd_pkg::HX_STOP : hex_ff;

      stat.line_end  = prev_cr_ff && (in_byte == chkd_pkg::CH_LF);
      stat.line_full = (count_ff == LC_W'(LINE_MAX - 1));
      stat.size_zero = (size_ff == '0);

      hex_in     = hex_ff;
      size_in    = size_ff;
      prev_cr_in = prev_cr_ff;
      count_in   = count_ff;

      if (restart) begin
         hex_in     = chkd_pkg::HX_BLANK;
         size_in    = '0;
         prev_cr_in = 1'b0;
         count_in   = '0;
      end else if (step && !stat.line_end) begin
         prev_cr_in = (in_byte == chkd_pkg::CH_CR);
         if (!stat.line_full) begin
            count_in = count_ff + 1'b1;
         end
         hex_in = hex_cur;
         if (in_byte != chkd_pkg::CH_CR) begin
            case (hex_cur)
               chkd_pkg::HX_BLANK: begin
                  if (in_byte == chkd_pkg::CH_SPACE || in_byte == chkd_pkg::CH_TAB) begin
                     hex_in = chkd_pkg::HX_BLANK;
                  end else if (in_byte == chkd_pkg::CH_PLUS) begin
                     hex_in = chkd_pkg::HX_SIGN;
                  end else if (in_byte == chkd_pkg::CH_ZERO) begin
                     hex_in = chkd_pkg::HX_ZERO;
                  end else if (is_digit) begin
                     size_in = acc;
                     hex_in  = chkd_pkg::HX_DIGITS;
                  end else begin
                     hex_in = chkd_pkg::HX_STOP;
                  end
               end
               chkd_pkg::HX_SIGN: begin
                  if (in_byte == chkd_pkg::CH_ZERO) begin
                     hex_in = chkd_pkg::HX_ZERO;
                  end else if (is_digit) begin
                     size_in = acc;
                     hex_in  = chkd_pkg::HX_DIGITS;
                  end else begin
                     hex_in = chkd_pkg::HX_STOP;
                  end
               end
               chkd_pkg::HX_ZERO: begin
                  if (in_byte == chkd_pkg::CH_LOW_X || in_byte == chkd_pkg::CH_UP_X) begin
                     hex_in = chkd_pkg::HX_DIGITS;
                  end else if (is_digit) begin
                     size_in = acc;
                     hex_in  = chkd_pkg::HX_DIGITS;
                  end else begin
                     hex_in = chkd_pkg::HX_STOP;
                  end
               end
               chkd_pkg::HX_DIGITS: begin
                  if (is_digit) begin
                     size_in = acc;
                  end else begin
                     hex_in = chkd_pkg::HX_STOP;
                  end
               end
               default: begin
                  hex_in = chkd_pkg::HX_STOP;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hex_ff     <= chkd_pkg::HX_BLANK;
         size_ff    <= '0;
         prev_cr_ff <= 1'b0;
         count_ff   <= '0;
      end else begin
         hex_ff     <= hex_in;
         size_ff    <= size_in;
         prev_cr_ff <= prev_cr_in;
         count_ff   <= count_in;
      end
   end

   assign size_value = size_ff;

endmodule

// ----- hdl/http_chunked_decoder_top.sv -----
// Channel   Direction  Handshake               Beat contents
// req_      in         req_valid / req_ready   in_byte, last_byte
// rsp_      out        rsp_valid / rsp_ready   out_byte, has_byte, final_res, status
//
// One beat is taken per cycle; its result is registered and appears on rsp_ the cycle after.
// A beat yields a result only when it carries a payload byte or is marked last.
// req_ready is high while the result register is empty or being emptied in the same cycle,
// so a stall on rsp_ holds back req_ only once a result is actually waiting.
// Synchronous active-high reset returns to the start of a size line with the result register
// empty; a beat marked last does the same to the framing state after producing its result.
module http_chunked_decoder_top #(
   parameter int LINE_MAX  = 16,
   parameter int SIZE_BITS = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  chkd_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output chkd_pkg::rsp_type rsp_data
);

   // Framing state. The size line itself is tracked in the parser.
   logic [1:0]           phase_ff, phase_in;
   logic [SIZE_BITS-1:0] remaining_ff, remaining_in;
   logic                 skip_count_ff, skip_count_in;
   logic                 outcome_bad_ff, outcome_bad_in;

   // Result register.
   logic                 rsp_valid_ff, rsp_valid_in;
   chkd_pkg::rsp_type    rsp_data_ff, rsp_data_in;

   logic                    accept;
   logic                    parse_step;
   logic                    parse_restart;
   chkd_pkg::line_stat_type line_stat;
   logic [SIZE_BITS-1:0]    size_value;
   logic [1:0]              status_raw;
   logic                    has_byte;
   logic                    skip_done;

   assign req_ready  = !rsp_valid_ff || rsp_ready;
   assign accept     = req_valid && req_ready;
   assign parse_step = accept && (phase_ff == chkd_pkg::PH_SIZE);
   // The gap after a payload ends on its second byte; the next size line opens then.
   assign skip_done  = accept && (phase_ff == chkd_pkg::PH_SKIP) && skip_count_ff;
   assign parse_restart = (accept && req_data.last_byte) || skip_done;

   chkd_line_parser #(
      .LINE_MAX  (LINE_MAX),
      .SIZE_BITS (SIZE_BITS)
   ) u_line_parser (
      .clock      (clock),
      .reset      (reset),
      .in_byte    (req_data.in_byte),
      .step       (parse_step),
      .restart    (parse_restart),
      .stat       (line_stat),
      .size_value (size_value)
   );

   // Framing control: one decision per beat, taken in the cycle the beat is accepted.
   always_comb begin
      phase_in       = phase_ff;
      remaining_in   = remaining_ff;
      skip_count_in  = skip_count_ff;
      outcome_bad_in = outcome_bad_ff;
      has_byte       = 1'b0;
      status_raw     = chkd_pkg::ST_IN_DATA;

      case (phase_ff)
         chkd_pkg::PH_SIZE: begin
            if (line_stat.line_end) begin
               if (line_stat.size_zero) begin
                  phase_in       = chkd_pkg::PH_DONE;
                  outcome_bad_in = 1'b0;
                  status_raw     = chkd_pkg::ST_ZERO_CHUNK;
               end else begin
                  remaining_in = size_value;
                  phase_in     = chkd_pkg::PH_DATA;
                  status_raw   = chkd_pkg::ST_IN_DATA;
               end
            end else begin
               // A line that runs past its limit condemns the rest of the body.
               if (line_stat.line_full) begin
                  phase_in       = chkd_pkg::PH_DONE;
                  outcome_bad_in = 1'b1;
               end
               status_raw = chkd_pkg::ST_MALFORMED;
            end
         end
         chkd_pkg::PH_DATA: begin
            has_byte     = 1'b1;
            remaining_in = remaining_ff - 1'b1;
            if (remaining_ff == SIZE_BITS'(1)) begin
               phase_in      = chkd_pkg::PH_SKIP;
               skip_count_in = 1'b0;
            end
         end
         chkd_pkg::PH_SKIP: begin
            if (skip_count_ff) begin
               skip_count_in = 1'b0;
               phase_in      = chkd_pkg::PH_SIZE;
            end else begin
               skip_count_in = 1'b1;
            end
         end
         default: begin
            status_raw = outcome_bad_ff ? chkd_pkg::ST_MALFORMED : chkd_pkg::ST_ZERO_CHUNK;
         end
      endcase

      // The last beat of a body leaves the decoder ready for the next body.
      if (req_data.last_byte) begin
         phase_in       = chkd_pkg::PH_SIZE;
         remaining_in   = '0;
         skip_count_in  = 1'b0;
         outcome_bad_in = 1'b0;
      end

      rsp_data_in.out_byte  = has_byte ? req_data.in_byte : 8'd0;
      rsp_data_in.has_byte  = has_byte;
      rsp_data_in.final_res = req_data.last_byte;
      rsp_data_in.status    = req_data.last_byte ? status_raw : chkd_pkg::ST_ZERO_CHUNK;

      if (accept && (has_byte || req_data.last_byte)) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= chkd_pkg::PH_SIZE;
         remaining_ff   <= '0;
         skip_count_ff  <= 1'b0;
         outcome_bad_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (accept) begin
            phase_ff       <= phase_in;
            remaining_ff   <= remaining_in;
            skip_count_ff  <= skip_count_in;
            outcome_bad_ff <= outcome_bad_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && (has_byte || req_data.last_byte)) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // A payload phase always has at least one byte left to pass.
   a_data_nonzero: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == chkd_pkg::PH_DATA) |-> (remaining_ff != '0))
      else $error("payload phase with no bytes remaining");

   // The skip counter only moves inside the gap after a payload.
   a_skip_idle: assert property (@(posedge clock) disable iff (reset)
      (phase_ff != chkd_pkg::PH_SKIP) |-> !skip_count_ff)
      else $error("skip counter set outside the skip phase");

   // A last beat returns the framing to the start of a size line.
   a_last_restarts: assert property (@(posedge clock) disable iff (reset)
      (accept && req_data.last_byte) |=> (phase_ff == chkd_pkg::PH_SIZE && !outcome_bad_ff))
      else $error("framing state not restarted after last beat");

   // Only a final result carries a non-zero status.
   a_status_final: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_data_ff.final_res) |-> (rsp_data_ff.status == chkd_pkg::ST_ZERO_CHUNK))
      else $error("status set on a non-final result");

endmodule
